// ===== src/bfiq_pkg.sv =====
// bfiq_pkg: shared types, codes and constants of the bloom filter block
// no dependencies; compiled first

package bfiq_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_MAX_BITS   = 65536;
    localparam int DEF_MAX_HASHES = 16;

    // field and register widths
    localparam int KEY_W      = 32;
    localparam int WORD_W     = 64;
    localparam int BITCNT_W   = 17;
    localparam int HASHCNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int STEP_W     = 6;

    // hash constants
    localparam logic [WORD_W-1:0] MIX_MULT  = 64'hff51afd7ed558ccd;
    localparam logic [WORD_W-1:0] GOLDEN    = 64'h9e3779b97f4a7c15;
    localparam int                MIX_SHIFT = 33;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 2'd1;

    // reset values of the configuration registers
    localparam logic [BITCNT_W-1:0]  BIT_COUNT_RST  = 17'h10000;
    localparam logic [HASHCNT_W-1:0] HASH_COUNT_RST = 5'd4;

    // operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_XS1,
        S_MUL,
        S_XS2,
        S_PCHK,
        S_DIV,
        S_ACCESS,
        S_CHECK,
        S_FINISH
    } state_t;

endpackage

// ===== src/bfiq_in_if.sv =====
// bfiq_in_if: request channel of the bloom filter (operation and key)
// no dependencies

interface bfiq_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

// ===== src/bfiq_out_if.sv =====
// bfiq_out_if: response channel of the bloom filter (query answer)
// no dependencies

interface bfiq_out_if;
    logic valid;
    logic ready;
    logic may_contain;

    modport source (output valid, output may_contain, input ready);
    modport sink   (input valid, input may_contain, output ready);
endinterface

// ===== src/bloom_filter_insert_query.sv =====
// bloom_filter_insert_query: double-hashing bloom filter, add and query
// one item at a time, a query ending early on a miss; the one shared 64-bit adder
//   runs the two 64-step multiplies of each item and one 64-step modulo per probe
// reset: async active low; a clearing pass then zeroes all MAX_BITS bits of the store
//   (configuration writes taken meanwhile); depends on bfiq_pkg, interfaces, alu, ram

module bloom_filter_insert_query
    import bfiq_pkg::*;
#(
    parameter int MAX_BITS   = DEF_MAX_BITS,
    parameter int MAX_HASHES = DEF_MAX_HASHES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bfiq_in_if.sink               req,
    bfiq_out_if.source            rsp
);

    localparam int AW = $clog2(MAX_BITS);

    // control state
    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic [BITCNT_W-1:0]    bit_count_reg, bit_count_next;
    logic [HASHCNT_W-1:0]   hash_count_reg, hash_count_next;
    logic                   out_valid_reg, out_valid_next;

    // payload state
    logic                   op_reg, op_next;
    logic                   pass_reg, pass_next;
    logic                   all_set_reg, all_set_next;
    logic                   out_data_reg, out_data_next;
    logic [WORD_W-1:0]      key_reg, key_next;
    logic [WORD_W-1:0]      v_reg, v_next;
    logic [WORD_W-1:0]      acc_reg, acc_next;
    logic [WORD_W-1:0]      mcand_reg, mcand_next;
    logic [WORD_W-1:0]      h1_reg, h1_next;
    logic [WORD_W-1:0]      h2_reg, h2_next;
    logic [WORD_W-1:0]      probe_reg, probe_next;
    logic [WORD_W-1:0]      dvd_reg, dvd_next;
    logic [BITCNT_W-1:0]    rem_reg, rem_next;
    logic [BITCNT_W-1:0]    div_reg, div_next;
    logic [HASHCNT_W-1:0]   probes_reg, probes_next;
    logic [HASHCNT_W-1:0]   idx_reg, idx_next;
    logic [STEP_W-1:0]      cnt_reg, cnt_next;

    // shared unit and bit store hookup
    logic [WORD_W-1:0]      alu_a, alu_b, alu_sum;
    logic                   alu_sub, alu_carry;
    logic                   ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0]          ram_addr;

    // combinational helpers
    logic [WORD_W-1:0]      xs_v, xs_acc;
    logic [BITCNT_W:0]      rem_shift;
    logic [BITCNT_W-1:0]    eff_div;
    logic [HASHCNT_W-1:0]   eff_probes;

    bfiq_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    bfiq_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BITS)
    ) u_bits (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.may_contain = out_data_reg;

    // divisor and probe count as seen by the next item
    always_comb
    begin
        // zero bit count behaves as one, large values clip to the store size
        priority if (bit_count_reg == '0)
            eff_div = {{(BITCNT_W-1){1'b0}}, 1'b1};
        else if (32'(bit_count_reg) > 32'(MAX_BITS))
            eff_div = BITCNT_W'(MAX_BITS);
        else
            eff_div = bit_count_reg;

        if (32'(hash_count_reg) > 32'(MAX_HASHES))
            eff_probes = HASHCNT_W'(MAX_HASHES);
        else
            eff_probes = hash_count_reg;
    end

    // configuration writes, unknown indexes dropped
    always_comb
    begin
        bit_count_next  = bit_count_reg;
        hash_count_next = hash_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIT_COUNT:  bit_count_next  = cfg_data;
                CFG_HASH_COUNT: hash_count_next = cfg_data[HASHCNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // sequencer: next state and datapath control
    always_comb
    begin
        xs_v      = v_reg ^ (v_reg >> MIX_SHIFT);
        xs_acc    = acc_reg ^ (acc_reg >> MIX_SHIFT);
        rem_shift = {rem_reg, dvd_reg[WORD_W-1]};

        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        out_valid_next = out_valid_reg;
        op_next       = op_reg;
        pass_next     = pass_reg;
        all_set_next  = all_set_reg;
        out_data_next = out_data_reg;
        key_next      = key_reg;
        v_next        = v_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        h1_next       = h1_reg;
        h2_next       = h2_reg;
        probe_next    = probe_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        probes_next   = probes_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;

        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = 1'b1;
        ram_addr  = AW'(rem_reg);

        // response slot frees when its transaction completes
        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = 1'b0;
                ram_addr  = clr_addr_reg;
                if (clr_addr_reg == AW'(MAX_BITS - 1))
                    state_next = S_IDLE;
                else
                    clr_addr_next = clr_addr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next    = {{(WORD_W-KEY_W){req.key[KEY_W-1]}}, req.key};
                    v_next      = {{(WORD_W-KEY_W){req.key[KEY_W-1]}}, req.key};
                    op_next     = req.op;
                    div_next    = eff_div;
                    probes_next = eff_probes;
                    pass_next   = 1'b0;
                    state_next  = S_XS1;
                end
            end
            S_XS1:
            begin
                mcand_next = xs_v;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // shift-add over the bits of the mix constant
                alu_a      = acc_reg;
                alu_b      = MIX_MULT[cnt_reg] ? mcand_reg : '0;
                acc_next   = alu_sum;
                mcand_next = mcand_reg << 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                    state_next = S_XS2;
            end
            S_XS2:
            begin
                if (!pass_reg)
                begin
                    h1_next    = xs_acc;
                    v_next     = key_reg ^ GOLDEN;
                    pass_next  = 1'b1;
                    state_next = S_XS1;
                end
                else
                begin
                    h2_next      = xs_acc | {{(WORD_W-1){1'b0}}, 1'b1};
                    probe_next   = h1_reg;
                    idx_next     = '0;
                    all_set_next = 1'b1;
                    state_next   = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (idx_reg == probes_reg)
                    state_next = (op_reg == OP_QUERY) ? S_FINISH : S_IDLE;
                else
                begin
                    dvd_next   = probe_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring remainder, one dividend bit per cycle
                alu_a    = WORD_W'(rem_shift);
                alu_b    = WORD_W'(div_reg);
                alu_sub  = 1'b1;
                rem_next = alu_carry ? alu_sum[BITCNT_W-1:0] : rem_shift[BITCNT_W-1:0];
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                    state_next = S_ACCESS;
            end
            S_ACCESS:
            begin
                // next probe position while the store is touched
                alu_a      = probe_reg;
                alu_b      = h2_reg;
                probe_next = alu_sum;
                if (op_reg == OP_ADD)
                begin
                    ram_we     = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PCHK;
                end
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!ram_rdata)
                begin
                    all_set_next = 1'b0;
                    state_next   = S_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PCHK;
                end
            end
            S_FINISH:
            begin
                // hold until the response slot is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = all_set_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            bit_count_reg  <= BIT_COUNT_RST;
            hash_count_reg <= HASH_COUNT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            bit_count_reg  <= bit_count_next;
            hash_count_reg <= hash_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pass_reg     <= pass_next;
        all_set_reg  <= all_set_next;
        out_data_reg <= out_data_next;
        key_reg      <= key_next;
        v_reg        <= v_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        h1_reg       <= h1_next;
        h2_reg       <= h2_next;
        probe_reg    <= probe_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        probes_reg   <= probes_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
    end

`ifndef SYNTHESIS
    // a request transaction takes the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("ready still high after a request transaction");

    // remainder stays below the divisor through the modulo
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV || state_reg == S_ACCESS) |-> rem_reg < div_reg)
        else $error("remainder reached the divisor");

    // the probe stride is odd once probing starts
    a_h2_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PCHK || state_reg == S_DIV) |-> h2_reg[0])
        else $error("second hash is even");

    // a query never writes the bit store
    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR && op_reg == OP_QUERY) |-> !ram_we)
        else $error("bit store written during a query");
`endif

endmodule

// ===== src/bfiq_ram.sv =====
// bfiq_ram: generic single-port ram with registered read
// no dependencies

module bfiq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== src/bfiq_alu.sv =====
// bfiq_alu: shared 64-bit add / subtract unit with carry out
// depends on bfiq_pkg

module bfiq_alu
    import bfiq_pkg::*;
(
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    input  logic              sub,
    output logic [WORD_W-1:0] sum,
    output logic              carry
);

    // carry set on subtract means a >= b
    always_comb
    begin
        {carry, sum} = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{WORD_W{1'b0}}, sub};
    end

endmodule

// ===== bench/bloom_filter_insert_query_tb.sv =====
// bloom_filter_insert_query_tb: self-checking bench for the double-hashing bloom filter
// drives add/query transactions, predicts every query answer with its own filter copy
// depends on bfiq_pkg, bfiq_in_if, bfiq_out_if and bloom_filter_insert_query

`timescale 1ns / 1ps

module bloom_filter_insert_query_tb;
    import bfiq_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    // covers the longest busy stretch of one item, at the largest probe count, rounded up
    localparam int SETTLE_CYCLES  = 1400;
    // covers the clearing pass after reset plus one slowest item, several times over
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int MODEL_BITS     = DEF_MAX_BITS;
    localparam int MODEL_HASHES   = DEF_MAX_HASHES;
    localparam int PHASES         = 9;
    localparam int PHASE_ITEMS    = 128;

    // register indexes that map to nothing, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bfiq_in_if  req_if ();
    bfiq_out_if rsp_if ();

    bloom_filter_insert_query u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    // predictor state: its own copy of the bit store and of both registers
    bit                 filter_mem [0:MODEL_BITS-1];
    bit [BITCNT_W-1:0]  model_bit_count  = BIT_COUNT_RST;
    bit [HASHCNT_W-1:0] model_hash_count = HASH_COUNT_RST;

    // answers still owed by the block, oldest first
    bit expected_answers [$];
    // keys added so far, used to build add-then-query sequences
    logic signed [KEY_W-1:0] added_keys [$];

    int  mismatches      = 0;
    int  items_sent      = 0;
    int  queries_sent    = 0;
    int  answers_checked = 0;
    int  settings_used   = 0;
    int  idle_cycles     = 0;
    // when set, neither side idles or stalls
    bit  no_idle         = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // -----------------------------------------------------------------
    // predictor
    // -----------------------------------------------------------------

    function automatic bit [WORD_W-1:0] mix64(input bit [WORD_W-1:0] x);
        bit [WORD_W-1:0] v;
        v = x ^ (x >> MIX_SHIFT);
        v = v * MIX_MULT;
        v = v ^ (v >> MIX_SHIFT);
        return v;
    endfunction

    // applies one transaction to the filter copy; returns 1 when it yields an answer
    function automatic bit probe_filter(input logic op, input logic [KEY_W-1:0] key,
                                        output bit answer);
        bit [WORD_W-1:0] wide_key;
        bit [WORD_W-1:0] h1;
        bit [WORD_W-1:0] h2;
        bit [WORD_W-1:0] divisor;
        bit [WORD_W-1:0] step;
        bit [WORD_W-1:0] pos;
        int              probes;
        bit              all_set;
        wide_key = {{(WORD_W - KEY_W){key[KEY_W-1]}}, key};
        h1 = mix64(wide_key);
        h2 = mix64(wide_key ^ GOLDEN) | 64'd1;
        // zero bit count acts as one, anything above the store size saturates
        divisor = WORD_W'(model_bit_count);
        if (divisor == 0)
            divisor = WORD_W'(1);
        if (divisor > WORD_W'(MODEL_BITS))
            divisor = WORD_W'(MODEL_BITS);
        probes = int'(model_hash_count);
        if (probes > MODEL_HASHES)
            probes = MODEL_HASHES;
        all_set = 1'b1;
        for (int i = 0; i < probes && all_set; i++)
        begin
            step = WORD_W'(i);
            pos  = (h1 + step * h2) % divisor;
            if (op == OP_ADD)
                filter_mem[int'(pos)] = 1'b1;
            else if (!filter_mem[int'(pos)])
                all_set = 1'b0;
        end
        answer = all_set;
        return (op == OP_QUERY);
    endfunction

    function automatic void model_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_BIT_COUNT)
            model_bit_count = data[BITCNT_W-1:0];
        else if (idx == CFG_HASH_COUNT)
            model_hash_count = data[HASHCNT_W-1:0];
    endfunction

    // -----------------------------------------------------------------
    // checking
    // -----------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic expv, input logic got);
        $display("[%0t] MISMATCH %s: expected %b, got %b", $realtime, what, expv, got);
        mismatches++;
    endtask

    task automatic check_answer(input logic got);
        bit expv;
        if (expected_answers.size() == 0)
        begin
            report_mismatch("answer with no query pending", 1'bx, got);
        end
        else
        begin
            expv = expected_answers.pop_front();
            if (got !== expv)
                report_mismatch("may_contain", expv, got);
            answers_checked++;
        end
    endtask

    // response side: random stalls, sometimes before the answer shows, sometimes after
    initial
    begin : answer_sink
        int stall;
        bit early;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 16);
            early = 1'($urandom_range(0, 1));
            if (no_idle || early)
            begin
                if (stall > 0)
                begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                rsp_if.ready <= 1'b1;
            end
            else
            begin
                // hold ready low until the answer is up, then stall on top of it
                rsp_if.ready <= 1'b0;
                @(posedge clk);
                while (rsp_if.valid !== 1'b1) @(posedge clk);
                repeat (stall) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end
            @(posedge clk);
            while (rsp_if.valid !== 1'b1) @(posedge clk);
            check_answer(rsp_if.may_contain);
        end
    end

    // watchdog: ends the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // -----------------------------------------------------------------
    // stimulus helpers
    // -----------------------------------------------------------------

    // one request transaction; called right after a rising edge.
    // valid is only dropped inside a gap so back-to-back items keep it high
    task automatic send_item(input logic op, input logic signed [KEY_W-1:0] key);
        int gap;
        bit answer;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.op    <= op;
        req_if.key   <= key;
        @(posedge clk);
        while (req_if.ready !== 1'b1) @(posedge clk);
        if (probe_filter(op, key, answer))
        begin
            expected_answers.push_back(answer);
            queries_sent++;
        end
        items_sent++;
    endtask

    // hold the sender until every owed answer has come back
    task automatic wait_answers_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_answers.size() != 0) @(posedge clk);
    endtask

    // an add leaves no answer behind, so let the slowest item finish as well
    task automatic settle_block();
        wait_answers_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] bits,
                              input logic [CFG_DATA_W-1:0] hashes);
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BIT_COUNT;
        cfg_data  <= bits;
        @(posedge clk);
        model_reg_write(CFG_BIT_COUNT, bits);
        cfg_index <= CFG_HASH_COUNT;
        cfg_data  <= hashes;
        @(posedge clk);
        model_reg_write(CFG_HASH_COUNT, hashes);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 15))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom();
        endcase
    endfunction

    // -----------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------

    // empty filter, reset settings: every query must miss
    task automatic test_reset_defaults();
        send_item(OP_QUERY, 32'sd0);
        send_item(OP_QUERY, -32'sd1);
        send_item(OP_QUERY, KEY_MIN);
        send_item(OP_QUERY, KEY_MAX);
    endtask

    // extreme keys and an alternating bit pattern, added then looked up; its opposite is only looked up
    task automatic test_add_then_query();
        logic signed [KEY_W-1:0] keys [5];
        keys = '{32'sd0, KEY_MIN, KEY_MAX, -32'sd1, 32'sh55555555};
        foreach (keys[i])
        begin
            send_item(OP_ADD, keys[i]);
            added_keys.push_back(keys[i]);
        end
        foreach (keys[i])
            send_item(OP_QUERY, keys[i]);
        send_item(OP_QUERY, 32'shaaaaaaaa);
    endtask

    // no probes: add is a no-op and any query answers 1
    task automatic test_zero_hashes();
        set_config(17'h10000, 17'd0);
        send_item(OP_ADD, 32'sh12345678);
        send_item(OP_QUERY, $urandom());
    endtask

    // divisor of zero acts as one; oversize bit and hash counts saturate
    task automatic test_count_limits();
        logic signed [KEY_W-1:0] k;
        set_config(17'd0, 17'd3);
        k = $urandom();
        send_item(OP_QUERY, k);
        send_item(OP_ADD, k);
        send_item(OP_QUERY, $urandom());
        set_config(17'h1ffff, 17'h1ffff);
        k = $urandom();
        send_item(OP_ADD, k);
        send_item(OP_QUERY, k);
    endtask

    // stored bits survive a divisor change; later probes use the new one
    task automatic test_divisor_change();
        logic signed [KEY_W-1:0] k;
        k = $urandom();
        set_config(17'd1000, 17'd5);
        send_item(OP_ADD, k);
        set_config(17'd1024, 17'd5);
        send_item(OP_QUERY, k);
    endtask

    // writes to unmapped indexes must not disturb either register
    task automatic test_spare_index();
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPARE_A;
        cfg_data  <= '1;
        @(posedge clk);
        model_reg_write(CFG_SPARE_A, '1);
        cfg_index <= CFG_SPARE_B;
        cfg_data  <= '0;
        @(posedge clk);
        model_reg_write(CFG_SPARE_B, '0);
        cfg_we    <= 1'b0;
        send_item(OP_QUERY, added_keys[0]);
    endtask

    // phases of mixed traffic, each under its own settings
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0]   bits;
        logic [CFG_DATA_W-1:0]   hashes;
        logic signed [KEY_W-1:0] k;
        int                      pick;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    bits   = 17'h10000;
                    hashes = 17'd16;
                end
                1:
                begin
                    bits   = 17'd1;
                    hashes = 17'd2;
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       bits = CFG_DATA_W'($urandom_range(0, 64));
                        1:       bits = CFG_DATA_W'($urandom_range(0, 17'h1ffff));
                        2:       bits = 17'h10000;
                        default: bits = CFG_DATA_W'($urandom_range(17'h10000, 17'h1ffff));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       hashes = 17'd0;
                        6:       hashes = CFG_DATA_W'($urandom_range(7, 16));
                        7:       hashes = CFG_DATA_W'($urandom_range(17, 31));
                        default: hashes = CFG_DATA_W'($urandom_range(1, 6));
                    endcase
                    // unused upper data bits of the hash count write
                    if ($urandom_range(0, 1))
                        hashes = hashes |
                                 CFG_DATA_W'($urandom_range(0, 4095) << HASHCNT_W);
                end
            endcase
            set_config(bits, hashes);
            no_idle = (phase % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mid-run the sender holds back until the block has answered everything
                if (phase == 4 && n == PHASE_ITEMS / 2)
                    wait_answers_drained();
                pick = $urandom_range(0, 9);
                if (pick <= 3 || added_keys.size() == 0)
                begin
                    k = pick_key();
                    send_item(OP_ADD, k);
                    added_keys.push_back(k);
                    if (added_keys.size() > 64)
                        void'(added_keys.pop_front());
                end
                else if (pick <= 6)
                begin
                    send_item(OP_QUERY, added_keys[$urandom_range(0, added_keys.size() - 1)]);
                end
                else if (pick <= 8)
                begin
                    send_item(OP_QUERY, pick_key());
                end
                else
                begin
                    send_item(OP_ADD, added_keys[$urandom_range(0, added_keys.size() - 1)]);
                end
            end
            no_idle = 1'b0;
        end
    endtask

    // -----------------------------------------------------------------
    // sequence
    // -----------------------------------------------------------------

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_BIT_COUNT;
        cfg_data     <= '0;
        req_if.valid <= 1'b0;
        req_if.op    <= OP_ADD;
        req_if.key   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the block clears its store first; requests simply wait for ready
        test_reset_defaults();
        test_add_then_query();
        test_zero_hashes();
        test_count_limits();
        test_divisor_change();
        test_spare_index();
        test_random_traffic();

        settle_block();
        $display("covered %0d transactions (%0d queries), %0d answers compared",
                 items_sent, queries_sent, answers_checked);
        $display("across %0d register settings incl. zero, saturated and spare indexes",
                 settings_used);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
